/* rtl/tlcv_pkg.sv */
// tlcv_pkg: shared constants, field widths and control structs for the
// terrain label cost volume block
// no dependencies
package tlcv_pkg;

  // default parameter values
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_LEVELS    = 30;
  localparam int DEF_RADIUS    = 3;

  // field widths
  localparam int HW    = 24;  // height and floor
  localparam int STW   = 23;  // segment step
  localparam int LBW   = 6;   // label index
  localparam int COSTW = 15;  // cost
  localparam int ATTRW = STW + HW + 1 + HW;

  // ports
  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 16;
  localparam int CFG_WW      = 11;
  localparam int CFG_HW      = 16;
  localparam int ROWW        = 16;

  localparam logic [CFG_AW-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_IDX_HEIGHT = 2'd1;

  localparam logic [CFG_WW-1:0] RST_WIDTH  = 11'd1024;
  localparam logic [CFG_HW-1:0] RST_HEIGHT = 16'd1024;

  // height limits in sixteenths of a metre
  localparam logic signed [HW-1:0] FALLBACK_LIMIT = -24'sd16000;
  localparam logic signed [HW-1:0] EXCLUDE_LIMIT  = -24'sd32000;

  // cost arithmetic
  localparam int DW       = HW + 1;      // magnitude of window min minus floor
  localparam int FRACW    = 16;          // cost scale 65536
  localparam int QW       = DW + FRACW;  // quotient bits
  localparam int ACCW     = QW + 2;
  localparam int CLIPW    = 20;
  localparam int EW       = 32;
  localparam logic [CLIPW-1:0] CLIP_MAX = 20'd655360;  // ten steps scaled
  localparam int RECIPW   = 21;
  localparam int RECIP_SH = 25;
  localparam logic [RECIPW-1:0] RECIP_30 = 21'd1118482;  // ceil(2^25 / 30)

  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic wmin;
    logic div_step;
    logic prep;
    logic calc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic center_row;
    logic center;
    logic excl;
    logic rd_last;
    logic div_last;
    logic out_free;
    logic lab_last;
  } stat_t;

endpackage

/* rtl/tlcv_ram.sv */
// tlcv_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module tlcv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/tlcv_ctrl.sv */
// tlcv_ctrl: sequencing state machine for one pixel at a time
// depends on tlcv_pkg
module tlcv_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  tlcv_pkg::stat_t stat,
  output tlcv_pkg::cmd_t  cmd
);
  import tlcv_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_READ = 8'b0000_0010,
    S_FOLD = 8'b0000_0100,
    S_WMIN = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_PREP = 8'b0010_0000,
    S_CALC = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid && stat.center_row) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        if (stat.rd_last) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        state_nxt = stat.center ? S_WMIN : S_IDLE;
      end
      S_WMIN: begin
        cmd.wmin  = 1'b1;
        state_nxt = stat.excl ? S_PREP : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.lab_last ? S_IDLE : S_CALC;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/tlcv_dp.sv */
// tlcv_dp: raster counters, line stores, window minimum, step divider and
// label cost datapath with output register
// depends on tlcv_pkg and tlcv_ram
module tlcv_dp #(
  parameter int MAX_WIDTH     = tlcv_pkg::DEF_MAX_WIDTH,
  parameter int LEVELS        = tlcv_pkg::DEF_LEVELS,
  parameter int WINDOW_RADIUS = tlcv_pkg::DEF_RADIUS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tlcv_pkg::cmd_t                   cmd,
  output tlcv_pkg::stat_t                  stat,
  input  logic [tlcv_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [tlcv_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tlcv_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_wr_en,
  input  logic [tlcv_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [tlcv_pkg::CFG_DW-1:0]      cfg_wdata
);
  import tlcv_pkg::*;

  localparam int WS     = 2 * WINDOW_RADIUS + 1;
  localparam int AR     = WINDOW_RADIUS + 1;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WEW    = $clog2(MAX_WIDTH + 1);
  localparam int SWH    = $clog2(WS);
  localparam int SWA    = (AR > 1) ? $clog2(AR) : 1;
  localparam int RCW    = $clog2(2 * WINDOW_RADIUS);
  localparam int DCW    = $clog2(QW);
  localparam int HDEPTH = WS * MAX_WIDTH;
  localparam int ADEPTH = AR * MAX_WIDTH;
  localparam int HAW    = $clog2(HDEPTH);
  localparam int AAW    = $clog2(ADEPTH);
  localparam int PADW   = OUT_TDATA_W - COSTW - LBW;

  // configuration and raster position
  logic [CFG_WW-1:0] img_w_r;
  logic [CFG_HW-1:0] img_h_r;
  logic [CW-1:0]     col_cnt_r;
  logic [ROWW-1:0]   row_cnt_r;
  logic [SWH-1:0]    hslot_r;
  logic [SWA-1:0]    aslot_r;
  logic [SWA-1:0]    cslot;
  logic [WEW-1:0]    w_eff;
  logic [CFG_HW-1:0] h_eff;
  logic              cfg_hit;

  // input fields
  logic signed [HW-1:0] px_hgt, px_floor;
  logic [STW-1:0]       px_step;
  logic                 px_excl;

  // line stores
  logic [HAW-1:0]   h_wr_addr, h_rd_addr;
  logic [HW-1:0]    h_rd_data;
  logic [AAW-1:0]   a_wr_addr, a_rd_addr;
  logic [ATTRW-1:0] a_rd_data;

  // per pixel job
  logic [CW-1:0]  cur_col_r;
  logic           center_r;
  logic [SWH-1:0] rd_slot_r;
  logic [RCW-1:0] rd_cnt_r;
  logic           rd_vld_r;
  logic signed [HW-1:0] col_r [WS];
  logic signed [HW-1:0] wmin, wsel;

  // center attributes
  logic signed [HW-1:0] c_hgt, c_floor;
  logic [STW-1:0]       c_step;
  logic                 c_excl;
  logic signed [DW-1:0] d0;

  // divider and label loop
  logic                   neg_r, exact_r;
  logic [QW-1:0]          quo_r;
  logic [STW-1:0]         rem_r;
  logic [DCW-1:0]         div_cnt_r;
  logic [STW:0]           rem_sh;
  logic                   ge;
  logic signed [ACCW-1:0] acc_r, mag;
  logic signed [EW-1:0]   e_r;
  logic [LBW-1:0]         lab_r;
  logic [CLIPW-1:0]       clip_r;
  logic                   forb_r, zero_r;
  logic [CLIPW+RECIPW-1:0] prod;

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_forb_r, out_last_r;

  assign px_hgt   = in_tdata[HW-1:0];
  assign px_floor = in_tdata[2*HW-1:HW];
  assign px_step  = in_tdata[2*HW+STW-1:2*HW];
  assign px_excl  = (px_hgt < EXCLUDE_LIMIT) || !in_tuser[0] || !in_tuser[1] ||
                    (px_step == '0);

  always_comb begin
    if (img_w_r == '0) begin
      w_eff = WEW'(1);
    end else if (32'(img_w_r) > MAX_WIDTH) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(img_w_r);
    end
    h_eff = (img_h_r == '0) ? CFG_HW'(1) : img_h_r;
  end

  assign cfg_hit = cfg_wr_en && (cfg_addr == CFG_IDX_WIDTH || cfg_addr == CFG_IDX_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r   <= RST_WIDTH;
      img_h_r   <= RST_HEIGHT;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      hslot_r   <= '0;
      aslot_r   <= '0;
    end else if (cfg_hit) begin
      if (cfg_addr == CFG_IDX_WIDTH) begin
        img_w_r <= cfg_wdata[CFG_WW-1:0];
      end else begin
        img_h_r <= cfg_wdata[CFG_HW-1:0];
      end
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      hslot_r   <= '0;
      aslot_r   <= '0;
    end else if (cmd.accept) begin
      if ((WEW+1)'(col_cnt_r) + (WEW+1)'(1) >= (WEW+1)'(w_eff)) begin
        col_cnt_r <= '0;
        if ((CFG_HW+1)'(row_cnt_r) + (CFG_HW+1)'(1) >= (CFG_HW+1)'(h_eff)) begin
          row_cnt_r <= '0;
          hslot_r   <= '0;
          aslot_r   <= '0;
        end else begin
          row_cnt_r <= row_cnt_r + ROWW'(1);
          hslot_r   <= (32'(hslot_r) == WS - 1) ? '0 : hslot_r + SWH'(1);
          aslot_r   <= (32'(aslot_r) == AR - 1) ? '0 : aslot_r + SWA'(1);
        end
      end else begin
        col_cnt_r <= col_cnt_r + CW'(1);
      end
    end
  end

  // line store addressing, centre row sits one slot after the current row
  assign cslot     = (32'(aslot_r) == AR - 1) ? '0 : aslot_r + SWA'(1);
  assign h_wr_addr = HAW'(int'(hslot_r) * MAX_WIDTH + int'(col_cnt_r));
  assign h_rd_addr = HAW'(int'(rd_slot_r) * MAX_WIDTH + int'(cur_col_r));
  assign a_wr_addr = AAW'(int'(aslot_r) * MAX_WIDTH + int'(col_cnt_r));
  assign a_rd_addr = AAW'(int'(cslot) * MAX_WIDTH + int'(col_cnt_r) - WINDOW_RADIUS);

  tlcv_ram #(.WIDTH(HW), .DEPTH(HDEPTH)) u_height_lines (
    .clk     (clk),
    .wr_en   (cmd.accept),
    .wr_addr (h_wr_addr),
    .wr_data (px_hgt),
    .rd_en   (cmd.rd_issue),
    .rd_addr (h_rd_addr),
    .rd_data (h_rd_data)
  );

  tlcv_ram #(.WIDTH(ATTRW), .DEPTH(ADEPTH)) u_attr_lines (
    .clk     (clk),
    .wr_en   (cmd.accept),
    .wr_addr (a_wr_addr),
    .wr_data ({px_step, px_floor, px_excl, px_hgt}),
    .rd_en   (cmd.accept),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd_data)
  );

  assign c_hgt   = a_rd_data[HW-1:0];
  assign c_excl  = a_rd_data[HW];
  assign c_floor = a_rd_data[2*HW:HW+1];
  assign c_step  = a_rd_data[ATTRW-1:2*HW+1];

  // column minima: newest column folds in the older rows as they are read
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int j = 0; j < WS - 1; j++) begin
        col_r[j] <= col_r[j+1];
      end
      col_r[WS-1] <= px_hgt;
    end else if (rd_vld_r && $signed(h_rd_data) < col_r[WS-1]) begin
      col_r[WS-1] <= h_rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      center_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_issue;
      if (cmd.accept) begin
        center_r <= (32'(row_cnt_r) >= 2 * WINDOW_RADIUS) &&
                    (32'(col_cnt_r) >= 2 * WINDOW_RADIUS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_col_r <= col_cnt_r;
      rd_slot_r <= (32'(hslot_r) == WS - 1) ? '0 : hslot_r + SWH'(1);
      rd_cnt_r  <= '0;
    end else if (cmd.rd_issue) begin
      rd_slot_r <= (32'(rd_slot_r) == WS - 1) ? '0 : rd_slot_r + SWH'(1);
      rd_cnt_r  <= rd_cnt_r + RCW'(1);
    end
  end

  always_comb begin
    wmin = col_r[0];
    for (int j = 1; j < WS; j++) begin
      if (col_r[j] < wmin) begin
        wmin = col_r[j];
      end
    end
    wsel = (wmin < FALLBACK_LIMIT) ? c_hgt : wmin;
    d0   = DW'(wsel) - DW'(c_floor);
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[QW-1]};
  assign ge     = rem_sh >= {1'b0, c_step};

  always_comb begin
    if (neg_r || acc_r >= 0) begin
      mag = acc_r;
    end else begin
      mag = -acc_r - ACCW'(!exact_r);
    end
  end

  assign prod = clip_r * RECIP_30;

  always_ff @(posedge clk) begin
    if (cmd.wmin) begin
      neg_r     <= d0[DW-1];
      quo_r     <= {(d0[DW-1] ? DW'(-d0) : DW'(d0)), FRACW'(0)};
      rem_r     <= '0;
      div_cnt_r <= '0;
      e_r       <= EW'(c_floor) - EW'(c_hgt) - EW'(c_step);
    end else if (cmd.div_step) begin
      quo_r     <= {quo_r[QW-2:0], ge};
      rem_r     <= ge ? STW'(rem_sh - {1'b0, c_step}) : STW'(rem_sh);
      div_cnt_r <= div_cnt_r + DCW'(1);
    end
    if (cmd.prep) begin
      acc_r   <= ACCW'(quo_r);
      exact_r <= (rem_r == '0);
      lab_r   <= '0;
    end else if (cmd.emit) begin
      acc_r <= neg_r ? acc_r + ACCW'(1 << FRACW) : acc_r - ACCW'(1 << FRACW);
      e_r   <= e_r + EW'(c_step);
      lab_r <= lab_r + LBW'(1);
    end
    if (cmd.calc) begin
      clip_r <= (mag >= ACCW'(CLIP_MAX)) ? CLIP_MAX : mag[CLIPW-1:0];
      forb_r <= !c_excl && (e_r > 0);
      zero_r <= c_excl || (e_r > 0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {PADW'(0), (zero_r ? COSTW'(0) : prod[RECIP_SH +: COSTW]), lab_r};
      out_forb_r <= forb_r;
      out_last_r <= (32'(lab_r) == LEVELS - 1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_forb_r;
  assign out_tlast  = out_last_r;

  assign stat.center_row = (32'(row_cnt_r) >= 2 * WINDOW_RADIUS);
  assign stat.center     = center_r;
  assign stat.excl       = c_excl;
  assign stat.rd_last    = (32'(rd_cnt_r) == 2 * WINDOW_RADIUS - 1);
  assign stat.div_last   = (32'(div_cnt_r) == QW - 1);
  assign stat.out_free   = !out_valid_r || out_tready;
  assign stat.lab_last   = (32'(lab_r) == LEVELS - 1);

endmodule

/* rtl/terrain_label_cost_volume.sv */
// terrain_label_cost_volume: top level, controller plus datapath
// depends on tlcv_pkg, tlcv_ctrl, tlcv_dp (and tlcv_ram below it)
//
//  channel | dir | transfer content
//  in_     | in  | one height pixel with mask, segment flag, floor, step
//  out_    | out | one label cost, LEVELS per interior centre pixel
//  cfg_    | in  | register write, index 0 width, 1 height
//
// a pixel in the first 2R rows of the frame is only accepted; any other pixel
// is followed by line store reads of the 2R older window rows and a fold step
// a centre adds a minimum step, the divider steps (skipped for excluded centres),
// a set-up step, and a calc step and an emit step per label
// reset is synchronous; line stores need no clearing pass
// a stalled output holds the label loop; the last result may wait while
// the next pixel is taken
module terrain_label_cost_volume #(
  parameter int MAX_WIDTH     = tlcv_pkg::DEF_MAX_WIDTH,
  parameter int LEVELS        = tlcv_pkg::DEF_LEVELS,
  parameter int WINDOW_RADIUS = tlcv_pkg::DEF_RADIUS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // height[23:0], segment_floor[47:24], segment_step[70:48], zero pad
  input  logic [tlcv_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mask_on[0], segment_valid[1]
  input  logic [tlcv_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // label[5:0], cost[20:6], zero pad
  output logic [tlcv_pkg::OUT_TDATA_W-1:0] out_tdata,
  // forbidden[0]
  output logic                             out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_wr_en,
  input  logic [tlcv_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [tlcv_pkg::CFG_DW-1:0]      cfg_wdata
);
  import tlcv_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tlcv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlcv_dp #(
    .MAX_WIDTH     (MAX_WIDTH),
    .LEVELS        (LEVELS),
    .WINDOW_RADIUS (WINDOW_RADIUS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

endmodule

/* sim/tb_terrain_label_cost_volume.sv */
// tb_terrain_label_cost_volume: self-checking testbench for the terrain label cost volume
// uses tlcv_pkg and terrain_label_cost_volume; a scoreboard class predicts label costs
module tb_terrain_label_cost_volume;
  import tlcv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = DEF_MAX_WIDTH;
  localparam int NLAB = DEF_LEVELS;
  localparam int RAD  = DEF_RADIUS;
  localparam int SIDE = 2 * RAD + 1;
  localparam int ATTR_ROWS = RAD + 1;
  localparam longint COST_CAP = (10 * 65536) / 30;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [CFG_AW-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_IDX_SPARE_B = 2'd3;

  typedef struct {
    logic signed [HW-1:0]  hgt;
    logic                  mask;
    logic                  segv;
    logic signed [HW-1:0]  flo;
    logic [STW-1:0]        step;
  } pixel_t;

  typedef struct packed {
    logic [LBW-1:0]   label;
    logic [COSTW-1:0] cost;
    logic             forb;
    logic             last;
  } label_cost_t;

  class cost_scoreboard;
    int width_reg = 1024;
    int height_reg = 1024;
    int col, row;
    int errors;
    longint hgt_lines[SIDE][MAXW];
    pixel_t attr_lines[ATTR_ROWS][MAXW];
    label_cost_t cost_q[$];

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      if (idx == CFG_IDX_WIDTH) width_reg = val[CFG_WW-1:0];
      else if (idx == CFG_IDX_HEIGHT) height_reg = val;
      else return;
      col = 0;
      row = 0;
    endfunction

    function int pending();
      return cost_q.size();
    endfunction

    function void note_pixel(pixel_t p);
      int w, h;
      longint wmin, st, lab, d, cost;
      pixel_t ctr;
      logic excl, forb;
      label_cost_t e;
      w = width_reg < 1 ? 1 : (width_reg > MAXW ? MAXW : width_reg);
      h = height_reg == 0 ? 1 : height_reg;
      hgt_lines[row % SIDE][col] = p.hgt;
      attr_lines[row % ATTR_ROWS][col] = p;
      if (row >= 2 * RAD && col >= 2 * RAD) begin
        ctr = attr_lines[(row - RAD) % ATTR_ROWS][col - RAD];
        wmin = hgt_lines[(row - 2 * RAD) % SIDE][col - 2 * RAD];
        for (int dr = 0; dr < SIDE; dr++)
          for (int dc = 0; dc < SIDE; dc++)
            if (hgt_lines[(row - 2 * RAD + dr) % SIDE][col - 2 * RAD + dc] < wmin)
              wmin = hgt_lines[(row - 2 * RAD + dr) % SIDE][col - 2 * RAD + dc];
        if (wmin < longint'(FALLBACK_LIMIT)) wmin = ctr.hgt;
        excl = ctr.hgt < EXCLUDE_LIMIT || !ctr.mask || !ctr.segv || ctr.step == 0;
        st = longint'(ctr.step);
        for (int i = 0; i < NLAB; i++) begin
          cost = 0;
          forb = 1'b0;
          if (!excl) begin
            lab = longint'(ctr.flo) + i * st;
            if (lab - longint'(ctr.hgt) > st) begin
              forb = 1'b1;
            end else begin
              d = wmin - lab;
              if (d < 0) d = -d;
              if (d >= 10 * st) cost = COST_CAP;
              else cost = (d * 65536) / (30 * st);
            end
          end
          e.label = LBW'(i);
          e.cost = COSTW'(cost);
          e.forb = forb;
          e.last = (i == NLAB - 1);
          cost_q.push_back(e);
        end
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check(label_cost_t got);
      label_cost_t e;
      if (cost_q.size() == 0) begin
        report($sformatf("unexpected label %0d cost %0d", got.label, got.cost));
        return;
      end
      e = cost_q.pop_front();
      if (got !== e)
        report($sformatf("label %0d/%0d cost %0d/%0d forbidden %0b/%0b last %0b/%0b",
                         got.label, e.label, got.cost, e.cost, got.forb, e.forb,
                         got.last, e.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid, in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [IN_TUSER_W-1:0] in_tuser;
  logic out_tvalid, out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser, out_tlast;
  logic cfg_wr_en;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  cost_scoreboard sb;
  int src_pct, sink_pct;
  logic hold_on;
  int quiet_cycles;

  terrain_label_cost_volume i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // result side: check each transfer, then choose the next ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready)
        sb.check('{out_tdata[LBW-1:0], out_tdata[LBW+COSTW-1:LBW], out_tuser, out_tlast});
      out_tready <= !hold_on && ($urandom_range(99) >= sink_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task cfg_write(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task send_pixel(pixel_t p);
    while (src_pct > 0 && $urandom_range(99) < src_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, p.step, p.flo, p.hgt};
    in_tuser  <= {p.segv, p.mask};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel(p);
  endtask

  task drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic pixel_t directed_pixel(int r, int c);
    pixel_t p;
    p.flo  = '0;
    p.step = STW'(16);
    p.hgt  = HW'(16 * ((r + c) % 8));
    p.mask = 1'b1;
    p.segv = 1'b1;
    if (c == 4 && r % 10 == 2) p.hgt = -24'sd8388608;
    if (c == RAD) begin
      case (r % 10)
        1: begin p.hgt = -24'sd20000; p.flo = -24'sd20100; end
        3: p.hgt = -24'sd32001;
        4: p.mask = 1'b0;
        5: p.segv = 1'b0;
        6: p.step = '0;
        7: begin p.hgt = 24'sd8388607; p.flo = -24'sd8388608; p.step = 23'd8388607; end
        8: p.flo = 24'sd2000;
        9: begin p.step = 23'd1; p.hgt = 24'sd500; end
        default: ;
      endcase
    end
    return p;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int k;
    k = $urandom_range(99);
    p.mask = 1'b1;
    p.segv = 1'b1;
    p.flo  = HW'($signed($urandom_range(4000)) - 2000);
    p.step = STW'($urandom_range(1, 64));
    p.hgt  = HW'(p.flo + $signed($urandom_range(31 * p.step)) - $signed(32'(p.step)));
    if (k < 5) begin
      p.step = '0;
    end else if (k < 11) begin
      p.hgt = HW'($urandom); p.flo = HW'($urandom); p.step = STW'($urandom);
      p.mask = 1'($urandom); p.segv = 1'($urandom);
    end else if (k < 15) begin
      p.hgt = HW'(-32001 - $signed($urandom_range(8000000)));
    end else if (k < 21) begin
      p.hgt = HW'(-16001 - $signed($urandom_range(15998)));
      p.flo = HW'(p.hgt - $signed($urandom_range(200)));
    end else if (k < 25) begin
      p.mask = 1'b0;
    end else if (k < 29) begin
      p.segv = 1'b0;
    end else if (k < 33) begin
      p.step = STW'($urandom);
    end
    return p;
  endfunction

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_wr_en = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    hold_on = 1'b0;
    src_pct = 0;
    sink_pct = 0;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // narrowest width, one centre per row from row 2R; special cases repeat each ten rows
    cfg_write(CFG_IDX_WIDTH, CFG_DW'(7));
    cfg_write(CFG_IDX_HEIGHT, CFG_DW'(16'hffff));
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 7; c++)
        send_pixel(directed_pixel(r, c));
    drain();

    // the frame carries on through the idling phases
    for (int m = 0; m < 4; m++) begin
      src_pct  = (m == 1) ? 61 : (m == 3) ? 13 : 0;
      sink_pct = (m == 2) ? 61 : (m == 3) ? 13 : 0;
      if (m == 0)
        fork
          begin
            hold_on <= 1'b1;
            repeat (800) @(posedge clk);
            hold_on <= 1'b0;
          end
        join_none
      repeat (40) send_pixel(rand_pixel());
      drain();
    end

    // unused indexes, then clamped full width
    src_pct = 0;
    sink_pct = 0;
    cfg_write(CFG_IDX_SPARE_A, CFG_DW'($urandom));
    cfg_write(CFG_IDX_SPARE_B, CFG_DW'($urandom));
    cfg_write(CFG_IDX_WIDTH, CFG_DW'(2047));
    cfg_write(CFG_IDX_HEIGHT, CFG_DW'(7));
    repeat (8) send_pixel(rand_pixel());
    drain();

    cfg_write(CFG_IDX_HEIGHT, CFG_DW'(16'hffff));
    cfg_write(CFG_IDX_WIDTH, CFG_DW'(0));
    repeat (12) send_pixel(rand_pixel());
    drain();
    cfg_write(CFG_IDX_HEIGHT, CFG_DW'(0));
    cfg_write(CFG_IDX_WIDTH, CFG_DW'(3));
    repeat (12) send_pixel(rand_pixel());
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
